// ===== hw/rtl/lpd_pkg.sv =====
package lpd_pkg;

	typedef enum logic [1:0] {
		ST_NEW      = 2'd0,
		ST_MERGED   = 2'd1,
		ST_OVERFLOW = 2'd2
	} lpd_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} lpd_state_t;

	typedef struct packed {
		logic vld;
		logic found;
	} lpd_tok_t;

	localparam int unsigned HALF_W  = 24;
	localparam int unsigned WORD_W  = 2 * HALF_W;
	localparam int unsigned OIDX_W  = 8;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic REG_MERGE_MARK = 1'b0;

endpackage

// ===== hw/rtl/lpd_cell.sv =====
module lpd_cell #(
	parameter int unsigned IDX_W    = 8,
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [IDX_W-1:0]                wr_idx,
	input  logic [lpd_pkg::WORD_W-1:0]      wr_value,
	input  logic                            wr_surv,
	input  logic [lpd_pkg::WORD_W-1:0]      word,
	input  logic [IDX_W-1:0]                count,
	input  lpd_pkg::lpd_tok_t               tok_in,
	input  logic [IDX_W-1:0]                idx_in,
	output lpd_pkg::lpd_tok_t               tok_out,
	output logic [IDX_W-1:0]                idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = CELL_IDX[IDX_W-1:0];

	logic [lpd_pkg::WORD_W-1:0] value_q;
	logic                       surv_q;
	logic                       hit;
	lpd_pkg::lpd_tok_t          tok_q;
	logic [IDX_W-1:0]           idx_q;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == MY_IDX) begin
			value_q <= wr_value;
			surv_q  <= wr_surv;
		end
	end

	assign hit = tok_in.vld && !tok_in.found && (MY_IDX < count) && surv_q
		&& (value_q == word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld   <= tok_in.vld;
			tok_q.found <= tok_in.found | hit;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= tok_in.found ? idx_in : MY_IDX;
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule

// ===== hw/rtl/literal_pool_dedup_table.sv =====
// Flow: a word that is not mergeable goes from idle to the done state, and its result is
// registered to the outputs once the output is free; a mergeable word walks the row of
// TABLE_DEPTH cells, one cell a cycle, and then enters the done state in the same way.
// A new word is accepted only in the idle state, after the previous result is registered.
// Reset: entry count and merge_mark clear to zero; stored entries are not cleared.
module literal_pool_dedup_table #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lpd_pkg::HALF_W-1:0]         value_high,
	input  logic [lpd_pkg::HALF_W-1:0]         value_low,
	input  logic [lpd_pkg::HALF_W-1:0]         reloc_high,
	input  logic [lpd_pkg::HALF_W-1:0]         reloc_low,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lpd_pkg::OIDX_W-1:0]         entry_index,
	output logic [1:0]                         status,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lpd_pkg::PADDR_W-1:0]        paddr,
	input  logic [lpd_pkg::PDATA_W-1:0]        pwdata,
	output logic [lpd_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	lpd_pkg::lpd_state_t            state_q, state_nxt;
	logic [lpd_pkg::HALF_W-1:0]     merge_mark_q;
	logic [lpd_pkg::WORD_W-1:0]     word_q;
	logic                           surv_q;
	logic                           found_q;
	logic [IDX_W-1:0]               fidx_q;
	logic [IDX_W-1:0]               count_q;
	logic                           launch_q;
	logic                           out_valid_q;
	logic [lpd_pkg::OIDX_W-1:0]     entry_index_q;
	lpd_pkg::lpd_status_t           status_q;

	logic                           acc;
	logic                           mergeable;
	logic                           surv_in;
	logic                           out_free;
	logic                           fin;
	logic                           full;
	logic                           wr_en;
	logic                           cfg_wr;
	logic [IDX_W-1:0]               res_idx;
	logic [IDX_W+lpd_pkg::OIDX_W-1:0] res_idx_ext;
	lpd_pkg::lpd_status_t           res_status;

	lpd_pkg::lpd_tok_t              tok   [0:TABLE_DEPTH];
	logic [IDX_W-1:0]               idx_c [0:TABLE_DEPTH];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lpd_pkg::REG_MERGE_MARK);
	assign prdata = (paddr[2] == lpd_pkg::REG_MERGE_MARK)
		? {{(lpd_pkg::PDATA_W - lpd_pkg::HALF_W){1'b0}}, merge_mark_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_mark_q <= '0;
		end else if (cfg_wr) begin
			merge_mark_q <= pwdata[lpd_pkg::HALF_W-1:0];
		end
	end

	assign acc       = in_valid && !in_stall;
	assign mergeable = (reloc_high == merge_mark_q) && (reloc_low == '0);
	assign surv_in   = (reloc_low == '0) && ((reloc_high & ~merge_mark_q) == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (count_q == LAST_IDX);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lpd_pkg::S_IDLE: begin
				if (acc) state_nxt = mergeable ? lpd_pkg::S_SEARCH : lpd_pkg::S_DONE;
			end
			lpd_pkg::S_SEARCH: begin
				if (tok[TABLE_DEPTH].vld) state_nxt = lpd_pkg::S_DONE;
			end
			lpd_pkg::S_DONE: begin
				if (out_free) state_nxt = lpd_pkg::S_IDLE;
			end
			default: state_nxt = lpd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		fin      = 1'b0;
		unique case (state_q)
			lpd_pkg::S_IDLE:   in_stall = 1'b0;
			lpd_pkg::S_SEARCH: in_stall = 1'b1;
			lpd_pkg::S_DONE:   fin      = out_free;
			default:           in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lpd_pkg::S_IDLE;
			launch_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			launch_q <= acc && mergeable;
			if (acc) begin
				found_q <= 1'b0;
			end else if (tok[TABLE_DEPTH].vld) begin
				found_q <= tok[TABLE_DEPTH].found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			word_q <= {value_high, value_low};
			surv_q <= surv_in;
		end
		if (tok[TABLE_DEPTH].vld) begin
			fidx_q <= idx_c[TABLE_DEPTH];
		end
	end

	assign tok[0]   = '{vld: launch_q, found: 1'b0};
	assign idx_c[0] = '0;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		lpd_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_idx   (count_q),
			.wr_value (word_q),
			.wr_surv  (surv_q),
			.word     (word_q),
			.count    (count_q),
			.tok_in   (tok[k]),
			.idx_in   (idx_c[k]),
			.tok_out  (tok[k+1]),
			.idx_out  (idx_c[k+1])
		);
	end

	assign wr_en = fin && !found_q && !full;

	always_comb begin
		priority if (found_q) begin
			res_idx    = fidx_q;
			res_status = lpd_pkg::ST_MERGED;
		end else if (full) begin
			res_idx    = '0;
			res_status = lpd_pkg::ST_OVERFLOW;
		end else begin
			res_idx    = count_q;
			res_status = lpd_pkg::ST_NEW;
		end
	end

	assign res_idx_ext = {{lpd_pkg::OIDX_W{1'b0}}, res_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) count_q <= count_q + 1'b1;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			entry_index_q <= res_idx_ext[lpd_pkg::OIDX_W-1:0];
			status_q      <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_index = entry_index_q;
	assign status      = status_q;

endmodule
